// ----- design/prsh_pkg.sv -----
// shared constants and types of the polynomial rolling string hash
package prsh_pkg;

	localparam int unsigned HASH_W = 30;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned PROD_W = 2 * HASH_W;

	// hash modulus and its doubled value for the final barrett correction
	localparam logic [HASH_W-1:0] PRIME = 30'd1000000009;
	localparam logic [HASH_W+1:0] PRIME_X2 = 32'd2000000018;

	// barrett factor floor(2^60 / prime), fits in 31 bits
	localparam logic [HASH_W:0] BARRETT_MU = 31'((64'd1 << PROD_W) / 64'd1000000009);

	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd96;

	localparam logic [HASH_W-1:0] TABLE_SIZE_RST = 30'd1024;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned DIV_STEPS = HASH_W;
	localparam int unsigned DIVCNT_W = $clog2(DIV_STEPS);

	// one classified byte waiting for the back end
	typedef struct packed {
		logic              last;
		logic [HASH_W-1:0] weight;
	} qent_t;

	// queue fill status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- design/prsh_front.sv -----
// front end: input transfer and letter weight classification
module prsh_front (
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [prsh_pkg::CHAR_W-1:0]        char_code,
	input  logic                               last,
	input  prsh_pkg::qstat_t                   qstat,
	output logic                               push,
	output prsh_pkg::qent_t                    entry
);

	logic [prsh_pkg::HASH_W-1:0] weight;

	// weight is byte minus 96 as a true residue mod the prime
	always_comb begin
		if (char_code >= prsh_pkg::LETTER_OFS) begin
			weight = prsh_pkg::HASH_W'(char_code - prsh_pkg::LETTER_OFS);
		end else begin
			weight = prsh_pkg::PRIME - prsh_pkg::HASH_W'(prsh_pkg::LETTER_OFS)
				+ prsh_pkg::HASH_W'(char_code);
		end
	end

	assign in_stall     = qstat.full;
	assign push         = in_valid && !qstat.full;
	assign entry.last   = last;
	assign entry.weight = weight;

endmodule

// ----- design/prsh_queue.sv -----
// short fifo between front and back ends
module prsh_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  prsh_pkg::qent_t  din,
	input  logic             pop,
	output prsh_pkg::qent_t  dout,
	output prsh_pkg::qstat_t qstat
);

	prsh_pkg::qent_t                  ent_q [prsh_pkg::QUEUE_DEPTH];
	logic [prsh_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [prsh_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [prsh_pkg::QCNT_W-1:0]      cnt_q;

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	assign dout        = ent_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == prsh_pkg::QCNT_W'(prsh_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);

endmodule

// ----- design/prsh_modred.sv -----
// four stage barrett reduction of a 60-bit value modulo the prime
module prsh_modred (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [prsh_pkg::PROD_W-1:0]   x,
	output logic                          done,
	output logic [prsh_pkg::HASH_W-1:0]   r
);

	localparam int unsigned W = prsh_pkg::HASH_W;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [2*W-1:0]        x_s1;
	logic [2*W+1:0]        q2_s1;
	logic [W+1:0]          xl_s2;
	logic [W+1:0]          t_s2;
	logic [W+1:0]          r_s3;
	logic [W-1:0]          r_s4;
	logic [W:0]            q3;
	logic [2*W:0]          qp;

	assign q3 = q2_s1[2*W+1:W+1];
	assign qp = (2*W+1)'(q3) * (2*W+1)'(prsh_pkg::PRIME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// remainder is below three primes, so only the low 32 bits matter after s1
	always_ff @(posedge clk) begin
		x_s1  <= x;
		q2_s1 <= (2*W+2)'(x[2*W-1:W-1]) * (2*W+2)'(prsh_pkg::BARRETT_MU);
		xl_s2 <= x_s1[W+1:0];
		t_s2  <= qp[W+1:0];
		r_s3  <= xl_s2 - t_s2;
		if (r_s3 >= prsh_pkg::PRIME_X2) begin
			r_s4 <= W'(r_s3 - prsh_pkg::PRIME_X2);
		end else if (r_s3 >= (W+2)'(prsh_pkg::PRIME)) begin
			r_s4 <= W'(r_s3 - (W+2)'(prsh_pkg::PRIME));
		end else begin
			r_s4 <= r_s3[W-1:0];
		end
	end

	assign done = v_s4;
	assign r    = r_s4;

endmodule

// ----- design/prsh_divider.sv -----
// restoring remainder unit, one quotient bit per cycle
module prsh_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [prsh_pkg::HASH_W-1:0]   dividend,
	input  logic [prsh_pkg::HASH_W-1:0]   divisor,
	output logic                          done,
	output logic [prsh_pkg::HASH_W-1:0]   rem
);

	localparam int unsigned W = prsh_pkg::HASH_W;

	logic                             busy_q;
	logic                             done_q;
	logic [prsh_pkg::DIVCNT_W-1:0]    cnt_q;
	logic [W-1:0]                     rem_q;
	logic [W-1:0]                     dvd_q;
	logic [W-1:0]                     dsr_q;
	logic [W:0]                       trial;
	logic [W-1:0]                     rem_next;
	logic                             last_step;

	assign trial     = {rem_q, dvd_q[W-1]};
	assign rem_next  = (trial >= {1'b0, dsr_q}) ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
	assign last_step = (cnt_q == prsh_pkg::DIVCNT_W'(prsh_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				// zero size means no reduction
				busy_q <= (divisor != '0);
				done_q <= (divisor == '0);
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= !last_step;
				done_q <= last_step;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (divisor == '0) ? dividend : '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- design/prsh_back.sv -----
// back end: hash and power update, bucket reduction, result register
module prsh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prsh_pkg::qstat_t              qstat,
	input  prsh_pkg::qent_t               head,
	output logic                          pop,
	input  logic [prsh_pkg::HASH_W-1:0]   table_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [prsh_pkg::HASH_W-1:0]   hash_value,
	output logic [prsh_pkg::HASH_W-1:0]   bucket
);

	localparam int unsigned W = prsh_pkg::HASH_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RED  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} bstate_t;

	bstate_t                   state_q;
	logic [W-1:0]              hash_q;
	logic [W-1:0]              power_q;
	logic                      last_q;
	logic [2*W-1:0]            prod_wp_q;
	logic [2*W-1:0]            prod_pw_q;
	logic                      red_start_q;
	logic                      div_start_q;
	logic [W-1:0]              fin_hash_q;
	logic                      out_valid_q;
	logic [W-1:0]              hash_value_q;
	logic [W-1:0]              bucket_q;

	logic                      done_wp, done_pw;
	logic [W-1:0]              r_wp, r_pw;
	logic                      div_done;
	logic [W-1:0]              div_rem;
	logic [W:0]                sum;
	logic [W-1:0]              sum_red;
	logic                      out_free;
	logic                      out_load;

	prsh_modred u_red_wp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start_q),
		.x      (prod_wp_q),
		.done   (done_wp),
		.r      (r_wp)
	);

	prsh_modred u_red_pw (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start_q),
		.x      (prod_pw_q),
		.done   (done_pw),
		.r      (r_pw)
	);

	prsh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (fin_hash_q),
		.divisor  (table_size),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign sum      = {1'b0, hash_q} + {1'b0, r_wp};
	assign sum_red  = (sum >= {1'b0, prsh_pkg::PRIME}) ? W'(sum - {1'b0, prsh_pkg::PRIME})
		: sum[W-1:0];
	assign pop      = (state_q == S_IDLE) && !qstat.empty;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hash_q      <= '0;
			power_q     <= W'(1);
			red_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			red_start_q <= pop;
			div_start_q <= (state_q == S_RED) && done_wp && done_pw && last_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (done_wp && done_pw) begin
						if (last_q) begin
							hash_q  <= '0;
							power_q <= W'(1);
							state_q <= S_DIV;
						end else begin
							hash_q  <= sum_red;
							power_q <= r_pw;
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// products for the reduction pipes and the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_wp_q <= (2*W)'(head.weight) * (2*W)'(power_q);
			prod_pw_q <= (2*W)'({power_q, 5'd0}) - (2*W)'(power_q);
			last_q    <= head.last;
		end
		if ((state_q == S_RED) && done_wp && last_q) begin
			fin_hash_q <= sum_red;
		end
		if (out_load) begin
			hash_value_q <= fin_hash_q;
			bucket_q     <= div_rem;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;
	assign bucket     = bucket_q;

	a_red_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		done_wp |-> state_q == S_RED)
		else $error("reduction finished outside its wait state");

	a_red_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_wp == done_pw)
		else $error("reduction pipes out of step");

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_wp |-> (r_wp < prsh_pkg::PRIME) && (r_pw < prsh_pkg::PRIME))
		else $error("reduced value not below the prime");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("remainder finished outside its wait state");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done && (table_size != '0) |-> div_rem < table_size)
		else $error("bucket not below table size");

endmodule

// ----- design/polynomial_rolling_string_hash.sv -----
// top level of the base 31 polynomial rolling string hash with bucket reduction
//
//   channel | signals                                  | direction | flow control
//   --------+------------------------------------------+-----------+-------------------
//   input   | in_valid, in_stall, char_code, last      | in        | valid / stall
//   output  | out_valid, out_stall, hash_value, bucket | out       | valid / stall
//   config  | cfg_valid, cfg_ready, table_size         | in        | valid / ready
//
// each byte passes through the back end in order: pop the queue and form the
//   products, run the barrett reduction pipe, then fold the result into the hash
// the final byte then waits for the bucket from the remainder unit, which
//   retires one bit per cycle, before the result register is loaded
// arst_n clears the hash to zero, the power to one and table_size to 1024
// in_stall rises only when the four-entry queue is full; out_stall holds the
//   result register, and the back end keeps working on the next string until
//   its final byte needs that register again
module polynomial_rolling_string_hash (
	input  logic                          clk,
	input  logic                          arst_n,

	// byte stream
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [prsh_pkg::CHAR_W-1:0]   char_code,
	input  logic                          last,

	// one result per string
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [prsh_pkg::HASH_W-1:0]   hash_value,
	output logic [prsh_pkg::HASH_W-1:0]   bucket,

	// bucket count register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [prsh_pkg::HASH_W-1:0]   table_size
);

	logic [prsh_pkg::HASH_W-1:0] table_size_q;
	prsh_pkg::qstat_t            qstat;
	prsh_pkg::qent_t             q_in;
	prsh_pkg::qent_t             q_head;
	logic                        q_push;
	logic                        q_pop;

	// always writable; sender must write only while no byte is in flight, unchecked
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= prsh_pkg::TABLE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= table_size;
		end
	end

	// front end turns each byte into its letter weight
	prsh_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last      (last),
		.qstat     (qstat),
		.push      (q_push),
		.entry     (q_in)
	);

	// decouples the input transfer from the multi-cycle arithmetic
	prsh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.dout   (q_head),
		.qstat  (qstat)
	);

	// back end does the modular arithmetic and owns the result register
	prsh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (q_head),
		.pop        (q_pop),
		.table_size (table_size_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.bucket     (bucket)
	);

endmodule
